@@ sv/shpt_pkg.sv @@
package shpt_pkg;

  // Table geometry. TABLE_SLOTS must be a power of two: the home slot is the
  // low bits of the hash.
  localparam int TABLE_SLOTS = 256;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int SLOT_OUT_W  = 8;

  localparam logic [31:0] PRIME_X = 32'd73856093;
  localparam logic [31:0] PRIME_Y = 32'd19349663;
  localparam logic [31:0] PRIME_Z = 32'd83492791;

  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_CREATED = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic {
    BK_IDLE,
    BK_PROBE
  } back_state_t;

  typedef struct packed {
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } key_t;

  // one hashed request on its way from front to back
  typedef struct packed {
    key_t              key;
    logic              create;
    logic [SLOT_W-1:0] home;
  } req_t;

endpackage

@@ sv/shpt_front.sv @@
module shpt_front import shpt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] coord_x,
  input  logic [31:0] coord_y,
  input  logic [31:0] coord_z,
  input  logic        create,
  output logic        push_valid,
  input  logic        push_ready,
  output req_t        push_req
);

  logic        a_valid;
  key_t        a_key;
  logic        a_create;
  logic [31:0] a_px;
  logic [31:0] a_py;
  logic [31:0] a_pz;
  logic [31:0] hash;
  logic        accept;

  assign in_ready = !a_valid || push_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (push_ready) begin
      a_valid <= 1'b0;
    end
  end

  // products mod 2^32, registered before the xor
  always_ff @(posedge clk) begin
    if (accept) begin
      a_key.x  <= coord_x;
      a_key.y  <= coord_y;
      a_key.z  <= coord_z;
      a_create <= create;
      a_px     <= coord_x * PRIME_X;
      a_py     <= coord_y * PRIME_Y;
      a_pz     <= coord_z * PRIME_Z;
    end
  end

  assign hash            = a_px ^ a_py ^ a_pz;
  assign push_valid      = a_valid;
  assign push_req.key    = a_key;
  assign push_req.create = a_create;
  assign push_req.home   = hash[SLOT_W-1:0];

endmodule

@@ sv/shpt_queue.sv @@
module shpt_queue import shpt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  req_t push_req,
  output logic pop_valid,
  input  logic pop,
  output req_t pop_req
);

  req_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_req    = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_req;
    end
  end

endmodule

@@ sv/shpt_back.sv @@
module shpt_back import shpt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  req_t                  q_req,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output status_t               out_status,
  output logic [SLOT_OUT_W-1:0] out_slot
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

  back_state_t        state, state_next;
  logic [SLOT_W-1:0]  idx, idx_next, idx_inc;
  logic [SLOT_W-1:0]  cnt, cnt_next;
  logic [SLOT_W-1:0]  rd_addr;
  key_t               job_key;
  logic               job_create;
  logic               load_job;
  key_t               key_mem [TABLE_SLOTS];
  key_t               rd_key;
  logic [TABLE_SLOTS-1:0] slot_valid;
  logic               wr_en;
  logic               out_free;
  logic               res_load;
  status_t            res_status;
  logic [SLOT_W-1:0]  res_slot;

  assign out_free = !out_valid || out_ready;
  assign idx_inc  = (idx == LAST_SLOT) ? '0 : idx + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cnt_next   = cnt;
    rd_addr    = idx;
    q_pop      = 1'b0;
    load_job   = 1'b0;
    wr_en      = 1'b0;
    res_load   = 1'b0;
    res_status = ST_FOUND;
    res_slot   = idx;
    unique case (state)
      BK_IDLE: begin
        rd_addr = q_req.home;
        if (q_valid) begin
          q_pop      = 1'b1;
          load_job   = 1'b1;
          idx_next   = q_req.home;
          cnt_next   = '0;
          state_next = BK_PROBE;
        end
      end
      BK_PROBE: begin
        // hold position while the previous result is still waiting
        if (out_free) begin
          if (slot_valid[idx]) begin
            if (rd_key == job_key) begin
              res_load   = 1'b1;
              res_status = ST_FOUND;
              state_next = BK_IDLE;
            end else if (cnt == LAST_SLOT) begin
              res_load   = 1'b1;
              res_status = ST_FULL;
              res_slot   = '0;
              state_next = BK_IDLE;
            end else begin
              idx_next = idx_inc;
              cnt_next = cnt + 1'b1;
              rd_addr  = idx_inc;
            end
          end else if (job_create) begin
            wr_en      = 1'b1;
            res_load   = 1'b1;
            res_status = ST_CREATED;
            state_next = BK_IDLE;
          end else begin
            res_load   = 1'b1;
            res_status = ST_ABSENT;
            res_slot   = '0;
            state_next = BK_IDLE;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    cnt <= cnt_next;
    if (load_job) begin
      job_key    <= q_req.key;
      job_create <= q_req.create;
    end
  end

  // key store: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[idx] <= job_key;
    end
    rd_key <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (wr_en) begin
      slot_valid[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status <= res_status;
      out_slot   <= SLOT_OUT_W'(res_slot);
    end
  end

  a_create_sets_valid: assert property (@(posedge clk) disable iff (rst)
    res_load && res_status == ST_CREATED |=> slot_valid[$past(idx)])
    else $error("created slot not marked used");

  a_full_means_all_used: assert property (@(posedge clk) disable iff (rst)
    res_load && res_status == ST_FULL |-> &slot_valid)
    else $error("full reported with an empty slot");

  a_absent_on_empty: assert property (@(posedge clk) disable iff (rst)
    res_load && res_status == ST_ABSENT |-> !slot_valid[idx] && !job_create)
    else $error("absent reported on a used slot or with create set");

  a_stall_holds_probe: assert property (@(posedge clk) disable iff (rst)
    state == BK_PROBE && !out_free |=> state == BK_PROBE && $stable(idx) && $stable(cnt))
    else $error("probe moved while output stalled");

endmodule

@@ sv/spatial_hash_probe_table.sv @@
// Path from an accepted request to its result: hash register, queue, queue pop with
// read issue, one probe step per probed slot, then the output register. The back
// takes a new request only once the last one has decided; each probed slot costs
// one key store read in the probe loop, and a full table is probed for a full lap.
// Reset: synchronous rst clears all slot valid bits at once, the queue and both
// handshakes; no clearing pass, requests are taken in the cycle after reset.
module spatial_hash_probe_table import shpt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // coord_x [31:0], coord_y [63:32], coord_z [95:64]
  input  logic         s_tuser,   // create_when_absent
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [7:0]   m_tdata,   // slot_index [7:0]
  output logic [1:0]   m_tuser    // lookup_status [1:0]
);

  logic    push_valid;
  logic    push_ready;
  req_t    push_req;
  logic    q_valid;
  logic    q_pop;
  req_t    q_req;
  status_t out_status;

  // front: register the coordinate and its three prime products
  shpt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .coord_x    (s_tdata[31:0]),
    .coord_y    (s_tdata[63:32]),
    .coord_z    (s_tdata[95:64]),
    .create     (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req)
  );

  // two-entry queue lets hashing run ahead of a long probe
  shpt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_req    (q_req)
  );

  // back: linear probe over the key store, result held in an output register
  shpt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_req      (q_req),
    .q_pop      (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_slot   (m_tdata)
  );

  assign m_tuser = out_status;

endmodule

@@ tb/sv/spatial_hash_probe_table_tb.sv @@
`timescale 1ns / 1ps

module spatial_hash_probe_table_tb;
  import shpt_pkg::*;

  // Hash multipliers, one per axis; products wrap at 32 bits.
  localparam logic [31:0] MUL_X = 32'd73856093;
  localparam logic [31:0] MUL_Y = 32'd19349663;
  localparam logic [31:0] MUL_Z = 32'd83492791;

  // Worst case: full table, a full lap of probes per request, plus long stalls on
  // both sides. The real run is far shorter than this.
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int SETTLE_CYCLES = 300;

  typedef struct packed {
    status_t    status;
    logic [7:0] slot;
  } lookup_t;

  // One row of the directed part. Rows with typed set carry their result;
  // all others are checked against the shadow table.
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    bit          create;
    bit          typed;
    status_t     status;
    logic [7:0]  slot;
  } cell_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;   // coord_x [31:0], coord_y [63:32], coord_z [95:64]
  logic        s_tuser = 1'b0; // create_when_absent
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // slot_index [7:0]
  logic [1:0]  m_tuser;        // lookup_status [1:0]

  spatial_hash_probe_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  // Shadow copy of the table: valid bits and keys.
  bit      shadow_valid [TABLE_SLOTS];
  key_t    shadow_key   [TABLE_SLOTS];
  key_t    known_cells  [$];   // every key stored so far, source of hits
  lookup_t pending_lookups [$];

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // Hash, then walk slots with wrap-around until hit, empty slot or full lap.
  function automatic lookup_t probe_slots(key_t k, bit create);
    logic [31:0] hash;
    int          idx;
    lookup_t     res;
    hash = (k.x * MUL_X) ^ (k.y * MUL_Y) ^ (k.z * MUL_Z);
    idx = int'(hash % 32'(TABLE_SLOTS));
    res.status = ST_FULL;
    res.slot = '0;
    for (int n = 0; n < TABLE_SLOTS; n++) begin
      if (shadow_valid[idx]) begin
        if (shadow_key[idx] == k) begin
          res.status = ST_FOUND;
          res.slot = 8'(idx);
          break;
        end
      end else if (create) begin
        shadow_valid[idx] = 1'b1;
        shadow_key[idx] = k;
        known_cells.push_back(k);
        res.status = ST_CREATED;
        res.slot = 8'(idx);
        break;
      end else begin
        res.status = ST_ABSENT;
        break;
      end
      idx = (idx + 1) % TABLE_SLOTS;
    end
    return res;
  endfunction

  // Random coordinate: a stored key (hit) with 100 - new_pct odds, else a
  // fresh one, mostly wide random, some near the origin, some at the
  // extremes, and some piled onto home slot 0 to grow a cluster.
  function automatic key_t pick_cell(int new_pct);
    logic [31:0] corner [5];
    key_t        k;
    int          kind;
    corner = '{32'h0000_0000, 32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff};
    if (known_cells.size() > 0 && $urandom_range(99) >= new_pct)
      return known_cells[$urandom_range(known_cells.size() - 1)];
    kind = $urandom_range(99);
    if (kind < 50) begin
      k.x = $urandom;
      k.y = $urandom;
      k.z = $urandom;
    end else if (kind < 80) begin
      k.x = 32'($urandom_range(16)) - 32'd8;
      k.y = 32'($urandom_range(16)) - 32'd8;
      k.z = 32'($urandom_range(16)) - 32'd8;
    end else if (kind < 92) begin
      k.x = corner[$urandom_range(4)];
      k.y = corner[$urandom_range(4)];
      k.z = corner[$urandom_range(4)];
    end else begin
      // a multiple of 256 on one axis leaves the home slot at 0
      k.x = {24'($urandom), 8'h00};
      k.y = '0;
      k.z = '0;
    end
    return k;
  endfunction

  // Offer one request after a random gap; on acceptance, run the shadow
  // table and queue the expected result (typed rows override the value).
  task automatic push_req(key_t k, bit create, bit typed, lookup_t typed_res);
    lookup_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {k.z, k.y, k.x};
    s_tuser  <= create;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    res = probe_slots(k, create);
    pending_lookups.push_back(typed ? typed_res : res);
  endtask

  task automatic run_random(int count, int create_pct, int new_pct);
    key_t    k;
    lookup_t unused;
    unused = '0;
    repeat (count) begin
      k = pick_cell(new_pct);
      push_req(k, $urandom_range(99) < create_pct, 1'b0, unused);
    end
  endtask

  // Result side: random back-pressure, compare each accepted result with the
  // oldest expectation.
  always @(posedge clk) begin
    lookup_t exp;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_lookups.size() == 0) begin
          $error("unexpected result: lookup_status %0d slot_index %0d", m_tuser, m_tdata);
          mismatch_count++;
        end else begin
          exp = pending_lookups.pop_front();
          if (m_tuser !== exp.status) begin
            $error("lookup_status: expected %0d, got %0d", exp.status, m_tuser);
            mismatch_count++;
          end
          if (m_tdata !== exp.slot) begin
            $error("slot_index: expected %0d, got %0d", exp.slot, m_tdata);
            mismatch_count++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Directed rows. Slot 0 is home for (0,0,0) and for any key whose set axes
  // are multiples of 256; x = 11 and x = 267 both hash to slot 255, so the
  // second one wraps past the end of the table.
  cell_row_t dir_rows [] = '{
    // lookup in an empty table
    '{32'h0, 32'h0, 32'h0, 1'b0, 1'b1, ST_ABSENT,  8'd0},
    '{32'h0, 32'h0, 32'h0, 1'b1, 1'b1, ST_CREATED, 8'd0},
    '{32'h0, 32'h0, 32'h0, 1'b0, 1'b1, ST_FOUND,   8'd0},
    // create on a hit just reports the hit
    '{32'h0, 32'h0, 32'h0, 1'b1, 1'b1, ST_FOUND,   8'd0},
    // same home, differs in x: probe past slot 0 to empty slot 1
    '{32'd256, 32'h0, 32'h0, 1'b0, 1'b1, ST_ABSENT, 8'd0},
    // keys differing from the resident only in y, only in z
    '{32'h0, 32'd256, 32'h0, 1'b1, 1'b0, ST_FOUND, 8'd0},
    '{32'h0, 32'h0, 32'd256, 1'b1, 1'b0, ST_FOUND, 8'd0},
    '{32'h0, 32'd256, 32'h0, 1'b0, 1'b0, ST_FOUND, 8'd0},
    '{32'h0, 32'h0, 32'd256, 1'b0, 1'b0, ST_FOUND, 8'd0},
    '{32'd256, 32'h0, 32'h0, 1'b0, 1'b0, ST_FOUND, 8'd0},
    // coordinate extremes
    '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 1'b0, ST_FOUND, 8'd0},
    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0, ST_FOUND, 8'd0},
    '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b0, ST_FOUND, 8'd0},
    '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 1'b1, 1'b0, ST_FOUND, 8'd0},
    '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 1'b0, ST_FOUND, 8'd0},
    '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 1'b0, 1'b0, ST_FOUND, 8'd0},
    // wrap from the last slot to slot 0
    '{32'd11,  32'h0, 32'h0, 1'b1, 1'b0, ST_FOUND, 8'd0},
    '{32'd267, 32'h0, 32'h0, 1'b1, 1'b0, ST_FOUND, 8'd0},
    '{32'd267, 32'h0, 32'h0, 1'b0, 1'b0, ST_FOUND, 8'd0},
    '{32'd523, 32'h0, 32'h0, 1'b0, 1'b0, ST_FOUND, 8'd0},
    '{32'd523, 32'h0, 32'h0, 1'b1, 1'b0, ST_FOUND, 8'd0}
  };

  initial begin
    key_t    k;
    lookup_t typed_res;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Phase 1: busy sender, heavy back-pressure.
    src_idle_pct = 16;
    snk_idle_pct = 72;
    foreach (dir_rows[i]) begin
      k.x = dir_rows[i].x;
      k.y = dir_rows[i].y;
      k.z = dir_rows[i].z;
      typed_res.status = dir_rows[i].status;
      typed_res.slot = dir_rows[i].slot;
      push_req(k, dir_rows[i].create, dir_rows[i].typed, typed_res);
    end
    run_random(350, 50, 65);

    // Hold requests off until every outstanding lookup has returned.
    s_tvalid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);

    // Phase 2: roles swapped; mostly creates of new keys, so the table fills
    // and later misses come back as table full.
    src_idle_pct = 72;
    snk_idle_pct = 16;
    run_random(330, 85, 80);

    // Phase 3: full rate both ways, hits mixed with full-table misses.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_random(250, 50, 50);

    s_tvalid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/shpt_pkg.sv
sv/shpt_front.sv
sv/shpt_queue.sv
sv/shpt_back.sv
sv/spatial_hash_probe_table.sv
tb/sv/spatial_hash_probe_table_tb.sv
